// File: design/agl_pkg.sv
// ----------------------------------------------------------------------------
// agl_pkg
// Types, blend mode codes, register indexes and divider sizing shared by
// the alpha gated luma blend and its pipelined divider.
// ----------------------------------------------------------------------------
package agl_pkg;

  typedef struct packed {
    logic [7:0] luma_a;
    logic [7:0] luma_b;
    logic [7:0] alpha_a;
    logic [7:0] alpha_b;
  } agl_in_t;

  typedef struct packed {
    logic [7:0] luma_out;
    logic       blended;
  } agl_out_t;

  typedef logic [5:0] blend_mode_t;

  localparam blend_mode_t BM_ADDITIVE     = 6'd0;
  localparam blend_mode_t BM_SUBTRACTIVE  = 6'd1;
  localparam blend_mode_t BM_MULTIPLY     = 6'd2;
  localparam blend_mode_t BM_DIVIDE       = 6'd3;
  localparam blend_mode_t BM_LIGHTEN      = 6'd4;
  localparam blend_mode_t BM_HARDLIGHT    = 6'd5;
  localparam blend_mode_t BM_DIFFERENCE   = 6'd6;
  localparam blend_mode_t BM_DIFF_NEG     = 6'd7;
  localparam blend_mode_t BM_EXCLUSIVE    = 6'd8;
  localparam blend_mode_t BM_BASECOLOR    = 6'd9;
  localparam blend_mode_t BM_FREEZE       = 6'd10;
  localparam blend_mode_t BM_UNFREEZE     = 6'd11;
  localparam blend_mode_t BM_AVERAGE      = 6'd12;
  localparam blend_mode_t BM_SUB_HALF     = 6'd13;
  localparam blend_mode_t BM_MAX_SEL      = 6'd14;
  localparam blend_mode_t BM_MIN_SEL      = 6'd15;
  localparam blend_mode_t BM_AVG_CLAMP    = 6'd16;
  localparam blend_mode_t BM_SUB_HALF2    = 6'd17;
  localparam blend_mode_t BM_SUB_DIST_LT  = 6'd18;
  localparam blend_mode_t BM_SUB_DIST_GT  = 6'd19;
  localparam blend_mode_t BM_MEAN_LT      = 6'd20;
  localparam blend_mode_t BM_ADD_CLAMP    = 6'd21;
  localparam blend_mode_t BM_ADD_SUB_HALF = 6'd22;
  localparam blend_mode_t BM_ADD_SUB      = 6'd23;
  localparam blend_mode_t BM_REFLECT      = 6'd24;
  localparam blend_mode_t BM_DIV_INV      = 6'd25;
  localparam blend_mode_t BM_SOFTBURN     = 6'd26;
  localparam blend_mode_t BM_INV_BURN     = 6'd27;
  localparam blend_mode_t BM_DODGE        = 6'd28;
  localparam blend_mode_t BM_ADD_CLAMP2   = 6'd29;
  localparam blend_mode_t BM_SUB_WRAP     = 6'd30;
  localparam blend_mode_t BM_EXPERIMENTAL = 6'd31;
  localparam blend_mode_t BM_GLOW         = 6'd32;

  localparam logic [1:0] CFG_BLEND_MODE = 2'd0;
  localparam logic [1:0] CFG_LUMA_LOW   = 2'd1;
  localparam logic [1:0] CFG_LUMA_HIGH  = 2'd2;

  localparam logic [7:0] LUMA_LOW_RST  = 8'd16;
  localparam logic [7:0] LUMA_HIGH_RST = 8'd235;

  // Divider: 20-bit dividend (17 used), 8-bit divisor, 4 bits per stage
  localparam int DIV_W     = 20;
  localparam int DIV_DEN_W = 8;
  localparam int DIV_BPS   = 4;
  localparam int DIV_STG   = DIV_W / DIV_BPS;
  localparam int DIV_LAT   = DIV_STG + 1;

endpackage

// File: design/alpha_gated_luma_blend.sv
// Throughput: one pixel per cycle while the output is not stalled. The path
// from an accepted input beat to its result beat is an input register, two
// chained 6-register divider pipelines and an output register.
// A stall on the output while out_valid is high freezes the whole pipeline; no beat is lost.
// Reset (synchronous, rst_n low) clears all valid bits and loads
// blend_mode 0, luma_low 16, luma_high 235.
// ----------------------------------------------------------------------------
// alpha_gated_luma_blend
// Per-pixel luma blend with alpha gating and 33 selectable blend mode codes.
// ----------------------------------------------------------------------------
module alpha_gated_luma_blend (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  agl_pkg::agl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output agl_pkg::agl_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import agl_pkg::*;

  typedef struct packed {
    blend_mode_t        mode;
    logic [7:0]         a;
    logic [7:0]         b;
    logic               pass;
    logic [7:0]         early;
    logic [7:0]         m9_c;
    logic signed [9:0]  m9_t;
  } ctx_a_t;

  typedef struct packed {
    logic [7:0] res;
    logic       blended;
    logic       use_c;
  } ctx_b_t;

  function automatic logic [7:0] clampy(input logic signed [18:0] v,
                                        input logic [7:0] lo,
                                        input logic [7:0] hi);
    if (v < $signed({11'd0, lo})) return lo;
    if (v > $signed({11'd0, hi})) return hi;
    return v[7:0];
  endfunction

  blend_mode_t mode_r;
  logic [7:0]  lo_r, hi_r;

  logic        adv;
  logic        s0_v_r;
  agl_in_t     s0_r;
  logic        va_r   [0:DIV_LAT-1];
  ctx_a_t      ctxa_r [0:DIV_LAT-1];
  logic        vb_r   [0:DIV_LAT-1];
  ctx_b_t      ctxb_r [0:DIV_LAT-1];
  logic        out_valid_r;
  agl_out_t    out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= BM_ADDITIVE;
      lo_r   <= LUMA_LOW_RST;
      hi_r   <= LUMA_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BLEND_MODE: mode_r <= cfg_data[5:0];
        CFG_LUMA_LOW:   lo_r   <= cfg_data;
        CFG_LUMA_HIGH:  hi_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // ---------------- prep stage (from input register) ----------------
  logic [7:0]         pa, pb;
  logic signed [18:0] sa, sb, s_a2b;
  logic [15:0]        prod_ab, prod_inv;
  logic [8:0]         sq_x, sqb_x;
  logic [17:0]        sq, sqb;
  logic [8:0]         ha, hb;
  logic [DIV_W-1:0]   num_a, num_b;
  logic [7:0]         den_a, den_b;
  ctx_a_t             ctx_p;

  always_comb begin
    logic [7:0] bb;
    pa      = s0_r.luma_a;
    pb      = s0_r.luma_b;
    sa      = $signed({11'd0, pa});
    sb      = $signed({11'd0, pb});
    s_a2b   = sa + (sb <<< 1) - 19'sd255;
    prod_ab  = pa * pb;
    prod_inv = (8'd255 - pa) * (8'd255 - pb);
    case (mode_r)
      BM_FREEZE:       sq_x = {1'b0, 8'd255 - pa};
      BM_UNFREEZE:     sq_x = {1'b0, 8'd255 - pb};
      BM_EXPERIMENTAL: sq_x = 9'd256 - {1'b0, pa};
      default:         sq_x = {1'b0, pa};
    endcase
    sqb_x = 9'd256 - {1'b0, pb};
    sq    = sq_x * sq_x;
    sqb   = sqb_x * sqb_x;
    ha    = {1'b0, pa} + 9'd255 - {1'b0, pb};
    hb    = {1'b0, pb} + 9'd255 - {1'b0, pa};

    num_a = {{(DIV_W-18){1'b0}}, sq};
    den_a = pb;
    case (mode_r)
      BM_DIVIDE:       num_a = {{(DIV_W-8){1'b0}}, pa};
      BM_UNFREEZE:     den_a = pa;
      BM_EXPERIMENTAL: den_a = pa;
      BM_DIV_INV: begin
        num_a = {{(DIV_W-8){1'b0}}, pa};
        den_a = 8'd255 - pb;
      end
      BM_GLOW:         den_a = (pb == 8'd255) ? 8'd1 : 8'd255 - pb;
      default: ;
    endcase
    num_b = {{(DIV_W-18){1'b0}}, sqb};
    den_b = pb;

    ctx_p.mode = mode_r;
    ctx_p.a    = pa;
    ctx_p.b    = pb;
    ctx_p.pass = (s0_r.alpha_a == 8'd0) || (s0_r.alpha_b == 8'd0)
                 || (mode_r > BM_GLOW) || (mode_r == BM_HARDLIGHT);
    ctx_p.m9_c = prod_ab[15:8];
    ctx_p.m9_t = 10'sd255 - $signed({2'b0, prod_inv[15:8]})
                 - $signed({2'b0, prod_ab[15:8]});

    bb = (pb <= lo_r) ? 8'd255 : pb;
    case (mode_r)
      BM_ADDITIVE, BM_ADD_SUB: ctx_p.early = clampy(s_a2b, lo_r, hi_r);
      BM_SUBTRACTIVE:  ctx_p.early = clampy(sa - sb, lo_r, hi_r);
      BM_MULTIPLY:     ctx_p.early = prod_ab[15:8];
      BM_LIGHTEN, BM_MAX_SEL: ctx_p.early = (pa > pb) ? pa : pb;
      BM_DIFFERENCE:   ctx_p.early = (pa > pb) ? pa - pb : pb - pa;
      BM_DIFF_NEG:     ctx_p.early = (sa + sb >= 19'sd255)
                                     ? 8'(9'd510 - {1'b0, pa} - {1'b0, pb})
                                     : pa + pb;
      BM_EXCLUSIVE:    ctx_p.early = clampy(s_a2b - $signed({11'd0, prod_ab[15:8]}),
                                            lo_r, hi_r);
      BM_AVERAGE:      ctx_p.early = {1'b0, pa[7:1]} + {1'b0, pb[7:1]};
      BM_SUB_HALF, BM_SUB_HALF2: ctx_p.early = ha[8:1];
      BM_MIN_SEL:      ctx_p.early = (pb < pa) ? pb : pa;
      BM_AVG_CLAMP:    ctx_p.early = clampy($signed({12'd0, pa[7:1]})
                                            + $signed({12'd0, pb[7:1]}), lo_r, hi_r);
      BM_SUB_DIST_LT:  ctx_p.early = (pb < pa) ? hb[8:1] : ha[8:1];
      BM_SUB_DIST_GT:  ctx_p.early = (pb > pa) ? hb[8:1] : ha[8:1];
      BM_MEAN_LT:      ctx_p.early = (pb < pa) ? 8'((({1'b0, pa} + {1'b0, pb}) >> 1)) : pa;
      BM_ADD_CLAMP, BM_ADD_CLAMP2: ctx_p.early = clampy(sa + sb, lo_r, hi_r);
      BM_ADD_SUB_HALF: ctx_p.early = clampy(s_a2b >>> 1, lo_r, hi_r);
      BM_SOFTBURN: begin
        if ({1'b0, pa} + {1'b0, pb} <= {1'b0, hi_r})
          ctx_p.early = (pa == hi_r) ? pa : ((pa == 8'd255) ? 8'd1 : 8'd0);
        else
          ctx_p.early = (pa <= 8'd127 && bb == 8'd1) ? 8'd254 : 8'd255;
      end
      BM_INV_BURN:     ctx_p.early = (pa <= lo_r)
                                     ? clampy($signed({11'd0, lo_r}), lo_r, hi_r)
                                     : clampy(19'sd255, lo_r, hi_r);
      BM_DODGE:        ctx_p.early = (pa >= hi_r) ? hi_r : 8'd0;
      BM_SUB_WRAP:     ctx_p.early = clampy($signed({11'd0, pa - pb}), lo_r, hi_r);
      default:         ctx_p.early = pa;
    endcase
  end

  logic [DIV_W-1:0] quo_a, quo_b, quo_c;

  agl_div u_div_a (.clk(clk), .en(adv), .num(num_a), .den(den_a), .quo(quo_a));
  agl_div u_div_b (.clk(clk), .en(adv), .num(num_b), .den(den_b), .quo(quo_b));

  // ---------------- mid stage (after first divide) ----------------
  ctx_a_t             cx;
  logic signed [18:0] qa_s, qb_s, p_s, q_s, m9_d;
  logic signed [18:0] m9_prod;
  logic [7:0]         p8;
  logic [17:0]        num3;
  logic [DIV_W-1:0]   num_c;
  logic [7:0]         den_c;
  ctx_b_t             ctx_m;

  always_comb begin
    cx      = ctxa_r[DIV_LAT-1];
    qa_s    = 19'sd255 - $signed({2'b0, quo_a[16:0]});
    qb_s    = 19'sd255 - $signed({2'b0, quo_b[16:0]});
    // shift the bracket before scaling by a
    m9_prod = $signed({1'b0, cx.a}) * (cx.m9_t >>> 8);
    m9_d    = $signed({11'd0, cx.m9_c}) + m9_prod;

    p_s = (cx.a <= lo_r) ? $signed({11'd0, lo_r}) : qa_s;
    if (p_s <= $signed({11'd0, lo_r})) p_s = $signed({11'd0, lo_r});
    p8  = p_s[7:0];
    q_s = (cx.b <= lo_r) ? $signed({11'd0, lo_r}) : qb_s;
    num3  = (9'd256 - {1'b0, p8}) * (9'd256 - {1'b0, cx.b});
    num_c = {{(DIV_W-18){1'b0}}, num3};
    den_c = q_s[7:0];

    ctx_m.use_c   = 1'b0;
    ctx_m.blended = !cx.pass;
    case (cx.mode)
      BM_DIVIDE:    ctx_m.res = (cx.b > lo_r) ? quo_a[7:0] : cx.a;
      BM_FREEZE:    ctx_m.res = (cx.b > lo_r) ? clampy(qa_s, lo_r, hi_r) : cx.a;
      BM_UNFREEZE:  ctx_m.res = (cx.a > lo_r) ? clampy(qa_s, lo_r, hi_r) : cx.a;
      BM_DIV_INV:   ctx_m.res = ((8'd255 - cx.b) > lo_r) ? quo_a[7:0] : cx.a;
      BM_GLOW:      ctx_m.res = quo_a[7:0];
      BM_BASECOLOR: ctx_m.res = clampy(m9_d, lo_r, hi_r);
      BM_EXPERIMENTAL: begin
        ctx_m.res   = lo_r;
        ctx_m.use_c = (q_s > $signed({11'd0, lo_r}));
      end
      default:      ctx_m.res = cx.early;
    endcase
    if (cx.pass) begin
      ctx_m.res   = cx.a;
      ctx_m.use_c = 1'b0;
    end
  end

  agl_div u_div_c (.clk(clk), .en(adv), .num(num_c), .den(den_c), .quo(quo_c));

  // ---------------- final selection ----------------
  agl_out_t out_nxt;

  always_comb begin
    out_nxt.blended  = ctxb_r[DIV_LAT-1].blended;
    out_nxt.luma_out = ctxb_r[DIV_LAT-1].use_c ? 8'd255 - quo_c[7:0]
                                               : ctxb_r[DIV_LAT-1].res;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        va_r[i] <= 1'b0;
        vb_r[i] <= 1'b0;
      end
    end else if (adv) begin
      s0_v_r  <= in_valid;
      va_r[0] <= s0_v_r;
      vb_r[0] <= va_r[DIV_LAT-1];
      for (int i = 1; i < DIV_LAT; i++) begin
        va_r[i] <= va_r[i-1];
        vb_r[i] <= vb_r[i-1];
      end
      out_valid_r <= vb_r[DIV_LAT-1];
    end
  end

  // payload, advance with the valid bits
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r      <= in_data;
      ctxa_r[0] <= ctx_p;
      ctxb_r[0] <= ctx_m;
      for (int i = 1; i < DIV_LAT; i++) begin
        ctxa_r[i] <= ctxa_r[i-1];
        ctxb_r[i] <= ctxb_r[i-1];
      end
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/agl_div.sv
// ----------------------------------------------------------------------------
// agl_div
// Pipelined unsigned restoring divider: input register, then four quotient
// bits per stage. Advances only when en is high.
// ----------------------------------------------------------------------------
module agl_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [agl_pkg::DIV_W-1:0]     num,
  input  logic [agl_pkg::DIV_DEN_W-1:0] den,
  output logic [agl_pkg::DIV_W-1:0]     quo
);
  import agl_pkg::*;

  logic [DIV_W-1:0]     wrk_r   [0:DIV_STG];
  logic [DIV_DEN_W-1:0] rem_r   [0:DIV_STG];
  logic [DIV_DEN_W-1:0] den_r   [0:DIV_STG];
  logic [DIV_W-1:0]     wrk_nxt [0:DIV_STG];
  logic [DIV_DEN_W-1:0] rem_nxt [0:DIV_STG];
  logic [DIV_DEN_W-1:0] den_nxt [0:DIV_STG];

  always_comb begin
    logic [DIV_W-1:0]     w;
    logic [DIV_DEN_W-1:0] r;
    logic [DIV_DEN_W:0]   t;
    wrk_nxt[0] = num;
    rem_nxt[0] = '0;
    den_nxt[0] = den;
    for (int s = 1; s <= DIV_STG; s++) begin
      w = wrk_r[s-1];
      r = rem_r[s-1];
      for (int j = 0; j < DIV_BPS; j++) begin
        // shift in the next dividend bit, subtract when it fits
        t = {r, w[DIV_W-1]};
        w = {w[DIV_W-2:0], 1'b0};
        if (t >= {1'b0, den_r[s-1]}) begin
          t    = t - {1'b0, den_r[s-1]};
          w[0] = 1'b1;
        end
        r = t[DIV_DEN_W-1:0];
      end
      wrk_nxt[s] = w;
      rem_nxt[s] = r;
      den_nxt[s] = den_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s <= DIV_STG; s++) begin
        wrk_r[s] <= wrk_nxt[s];
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= den_nxt[s];
      end
    end
  end

  assign quo = wrk_r[DIV_STG];

endmodule
